/* rtl/core/rinv_pkg.sv */
// shared constants and types for the radical inverse sample generator
`default_nettype none
package rinv_pkg;

  localparam int INDEX_BITS  = 32;
  localparam int FRAC_BITS   = 32;
  localparam int DIGIT_BITS  = 8;
  localparam int STACK_DEPTH = INDEX_BITS;
  localparam int DEPTH_BITS  = $clog2(STACK_DEPTH + 1);
  localparam int STEP_BITS   = 8;
  localparam int STEPS       = INDEX_BITS / STEP_BITS;
  localparam int STEP_CBITS  = $clog2(STEPS);
  localparam int QCNT_BITS   = $clog2(FRAC_BITS);
  localparam int REG_BITS    = 2;
  localparam int DATA_BITS   = 32;

  // register indexes
  localparam logic [REG_BITS-1:0] REG_KIND   = 2'd0;
  localparam logic [REG_BITS-1:0] REG_FIRST  = 2'd1;
  localparam logic [REG_BITS-1:0] REG_SECOND = 2'd2;
  localparam logic [REG_BITS-1:0] REG_COUNT  = 2'd3;

  // sequence kinds
  localparam logic KIND_HAMMERSLEY = 1'b0;
  localparam logic KIND_HALTON     = 1'b1;

  typedef enum logic [1:0] {
    AX_IDLE,
    AX_EXTRACT,
    AX_HORNER
  } axis_state_t;

  typedef struct packed {
    logic start;
  } unit_ctrl_t;

endpackage
`default_nettype wire

/* rtl/core/radical_inverse_sequence.sv */
// one item at a time; each axis runs one restoring division per base digit of the index,
// once in extraction and once in horner; the hammersley divider runs beside them for any
// index below sample_count, in either sequence kind, and a result is loaded only when all
// three are done; a finished point waits in the output register
// the next index can transfer in the cycle after the point is loaded
// synchronous reset restores sequence_kind 0, bases 2 and 3, sample_count 1024
`default_nettype none
module radical_inverse_sequence (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           write_enable,
  input  logic [rinv_pkg::REG_BITS-1:0]   reg_index,
  input  logic [rinv_pkg::DATA_BITS-1:0]  write_data,
  input  logic                           sample_valid,
  output logic                           sample_ready,
  input  logic [31:0]                    sample_index,
  output logic                           result_valid,
  input  logic                           result_ready,
  output logic [31:0]                    x_frac,
  output logic [31:0]                    y_frac,
  output logic                           index_beyond_count
);
  import rinv_pkg::*;

  logic                   sequence_kind;
  logic [DIGIT_BITS-1:0]  first_base, second_base;
  logic [DATA_BITS-1:0]   sample_count;
  logic                   pending, load;
  unit_ctrl_t             ctrl;
  logic                   busy_a, busy_b, busy_f, beyond;
  logic [FRAC_BITS-1:0]   val_a, val_b, quot;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      sequence_kind <= KIND_HAMMERSLEY;
      first_base    <= DIGIT_BITS'(2);
      second_base   <= DIGIT_BITS'(3);
      sample_count  <= DATA_BITS'(1024);
    end else if (write_enable) begin
      case (reg_index)
        REG_KIND:   sequence_kind <= write_data[0];
        REG_FIRST:  first_base    <= write_data[DIGIT_BITS-1:0];
        REG_SECOND: second_base   <= write_data[DIGIT_BITS-1:0];
        REG_COUNT:  sample_count  <= write_data;
        default:    ;
      endcase
    end
  end

  assign sample_ready = !pending;
  assign ctrl.start   = sample_valid && sample_ready;
  assign load = pending && !busy_a && !busy_b && !busy_f && (!result_valid || result_ready);

  rinv_axis u_axis_a (
    .clk   (clk),
    .rst   (rst),
    .ctrl  (ctrl),
    .index (sample_index[INDEX_BITS-1:0]),
    .base  (first_base),
    .busy  (busy_a),
    .value (val_a)
  );

  rinv_axis u_axis_b (
    .clk   (clk),
    .rst   (rst),
    .ctrl  (ctrl),
    .index (sample_index[INDEX_BITS-1:0]),
    .base  (second_base),
    .busy  (busy_b),
    .value (val_b)
  );

  rinv_frac_div u_frac (
    .clk    (clk),
    .rst    (rst),
    .ctrl   (ctrl),
    .index  (sample_index[INDEX_BITS-1:0]),
    .count  (sample_count),
    .busy   (busy_f),
    .quot   (quot),
    .beyond (beyond)
  );

  // item in flight and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      pending      <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      if (ctrl.start) begin
        pending <= 1'b1;
      end else if (load) begin
        pending <= 1'b0;
      end
      if (load) begin
        result_valid <= 1'b1;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (load) begin
      if (sequence_kind == KIND_HALTON) begin
        x_frac             <= val_a;
        y_frac             <= val_b;
        index_beyond_count <= 1'b0;
      end else begin
        x_frac             <= quot;
        y_frac             <= val_a;
        index_beyond_count <= beyond;
      end
    end
  end

endmodule
`default_nettype wire

/* rtl/core/rinv_digit_cell.sv */
// one cell of the digit stack, shifts toward top or bottom
`default_nettype none
module rinv_digit_cell (
  input  logic                           clk,
  input  logic                           push,
  input  logic                           pop,
  input  logic [rinv_pkg::DIGIT_BITS-1:0] shallow,
  input  logic [rinv_pkg::DIGIT_BITS-1:0] deep,
  output logic [rinv_pkg::DIGIT_BITS-1:0] digit
);
  import rinv_pkg::*;

  // take from the shallower neighbor on push, the deeper one on pop
  always_ff @(posedge clk) begin
    if (push) begin
      digit <= shallow;
    end else if (pop) begin
      digit <= deep;
    end
  end

endmodule
`default_nettype wire

/* rtl/core/rinv_axis.sv */
// radical inverse of one axis: digit extraction then horner over a cell stack
`default_nettype none
module rinv_axis (
  input  logic                           clk,
  input  logic                           rst,
  input  rinv_pkg::unit_ctrl_t           ctrl,
  input  logic [rinv_pkg::INDEX_BITS-1:0] index,
  input  logic [rinv_pkg::DIGIT_BITS-1:0] base,
  output logic                           busy,
  output logic [rinv_pkg::FRAC_BITS-1:0]  value
);
  import rinv_pkg::*;

  axis_state_t                state, state_next;
  logic [DIGIT_BITS-1:0]      divisor;
  logic [INDEX_BITS-1:0]      num;
  logic [DIGIT_BITS-1:0]      rem;
  logic [STEP_CBITS-1:0]      step;
  logic [DEPTH_BITS-1:0]      depth;
  logic [DIGIT_BITS-1:0]      stack [STACK_DEPTH];
  logic                       push, pop, last_step;
  logic [DIGIT_BITS-1:0]      rem_start, rem_div;
  logic [INDEX_BITS-1:0]      num_div;
  logic [DIGIT_BITS:0]        trial;

  assign last_step = (step == STEP_CBITS'(STEPS - 1));

  // horner starts each division from the top digit, extraction from zero
  always_comb begin
    if (step == '0) begin
      rem_start = (state == AX_HORNER) ? stack[0] : '0;
    end else begin
      rem_start = rem;
    end
  end

  // eight restoring division steps per cycle
  always_comb begin
    rem_div = rem_start;
    num_div = num;
    trial   = '0;
    for (int i = 0; i < STEP_BITS; i++) begin
      trial   = {rem_div, num_div[INDEX_BITS-1]};
      num_div = {num_div[INDEX_BITS-2:0], 1'b0};
      if (trial >= {1'b0, divisor}) begin
        trial      = trial - {1'b0, divisor};
        num_div[0] = 1'b1;
      end
      rem_div = trial[DIGIT_BITS-1:0];
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      AX_IDLE: begin
        if (ctrl.start) begin
          state_next = (index != '0) ? AX_EXTRACT : AX_HORNER;
        end
      end
      AX_EXTRACT: begin
        if (last_step && num_div == '0) begin
          state_next = AX_HORNER;
        end
      end
      AX_HORNER: begin
        if (depth == '0) begin
          state_next = AX_IDLE;
        end
      end
      default: state_next = AX_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    push = (state == AX_EXTRACT) && last_step;
    pop  = (state == AX_HORNER) && (depth != '0) && last_step;
    busy = (state != AX_IDLE);
  end

  assign value = num;

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= AX_IDLE;
      step  <= '0;
      depth <= '0;
    end else begin
      state <= state_next;
      if (state == AX_IDLE) begin
        step  <= '0;
        depth <= '0;
      end else if (state == AX_EXTRACT || depth != '0) begin
        step <= step + 1'b1;
        if (push) begin
          depth <= depth + 1'b1;
        end else if (pop) begin
          depth <= depth - 1'b1;
        end
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (state == AX_IDLE) begin
      if (ctrl.start) begin
        num     <= index;
        rem     <= '0;
        divisor <= (base < DIGIT_BITS'(2)) ? DIGIT_BITS'(2) : base;
      end
    end else if (state == AX_EXTRACT || depth != '0) begin
      num <= num_div;
      rem <= rem_div;
    end
  end

  // digit stack, top at cell zero
  for (genvar k = 0; k < STACK_DEPTH; k++) begin : g_cell
    logic [DIGIT_BITS-1:0] shallow, deep;
    if (k == 0) begin : g_top
      assign shallow = rem_div;
    end else begin : g_mid
      assign shallow = stack[k-1];
    end
    if (k == STACK_DEPTH - 1) begin : g_bot
      assign deep = '0;
    end else begin : g_low
      assign deep = stack[k+1];
    end
    rinv_digit_cell u_cell (
      .clk     (clk),
      .push    (push),
      .pop     (pop),
      .shallow (shallow),
      .deep    (deep),
      .digit   (stack[k])
    );
  end

endmodule
`default_nettype wire

/* rtl/core/rinv_frac_div.sv */
// bit-serial fraction divider for the hammersley x coordinate
`default_nettype none
module rinv_frac_div (
  input  logic                           clk,
  input  logic                           rst,
  input  rinv_pkg::unit_ctrl_t           ctrl,
  input  logic [rinv_pkg::INDEX_BITS-1:0] index,
  input  logic [rinv_pkg::DATA_BITS-1:0]  count,
  output logic                           busy,
  output logic [rinv_pkg::FRAC_BITS-1:0]  quot,
  output logic                           beyond
);
  import rinv_pkg::*;

  logic                  running;
  logic [QCNT_BITS-1:0]  cnt;
  logic [DATA_BITS:0]    r, r_shift, r_next;
  logic                  qbit;

  // one quotient bit per cycle
  always_comb begin
    r_shift = {r[DATA_BITS-1:0], 1'b0};
    qbit    = (r_shift >= {1'b0, count});
    r_next  = qbit ? (r_shift - {1'b0, count}) : r_shift;
  end

  assign busy = running;

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      cnt     <= '0;
    end else if (ctrl.start) begin
      running <= ({{(DATA_BITS-INDEX_BITS){1'b0}}, index} < count);
      cnt     <= '0;
    end else if (running) begin
      cnt <= cnt + 1'b1;
      if (cnt == QCNT_BITS'(FRAC_BITS - 1)) begin
        running <= 1'b0;
      end
    end
  end

  // datapath, saturates when the index is not below the count
  always_ff @(posedge clk) begin
    if (ctrl.start) begin
      r <= {1'b0, index};
      if ({{(DATA_BITS-INDEX_BITS){1'b0}}, index} >= count) begin
        beyond <= 1'b1;
        quot   <= '1;
      end else begin
        beyond <= 1'b0;
        quot   <= '0;
      end
    end else if (running) begin
      r    <= r_next;
      quot <= {quot[FRAC_BITS-2:0], qbit};
    end
  end

endmodule
`default_nettype wire

/* rtl/core/rinv_checker.sv */
// port-level checks for the radical inverse sample generator
`default_nettype none
module rinv_checker (
  input logic        clk,
  input logic        rst,
  input logic        sample_valid,
  input logic        sample_ready,
  input logic        result_valid,
  input logic        result_ready,
  input logic [31:0] x_frac,
  input logic        index_beyond_count
);

  // a stalled result stays offered
  a_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> result_valid)
    else $error("result dropped while stalled");

  // one item in flight: no new transfer right after one
  a_single: assert property (@(posedge clk) disable iff (rst)
    sample_valid && sample_ready |=> !sample_ready)
    else $error("input taken while busy");

  // a new result only follows an item in flight
  a_cause: assert property (@(posedge clk) disable iff (rst)
    $rose(result_valid) |-> $past(!sample_ready))
    else $error("result without an item");

  // flagged index saturates x
  a_sat: assert property (@(posedge clk) disable iff (rst)
    result_valid && index_beyond_count |-> x_frac == 32'hFFFF_FFFF)
    else $error("flagged x not saturated");

endmodule

bind radical_inverse_sequence rinv_checker u_rinv_checker (
  .clk                (clk),
  .rst                (rst),
  .sample_valid       (sample_valid),
  .sample_ready       (sample_ready),
  .result_valid       (result_valid),
  .result_ready       (result_ready),
  .x_frac             (x_frac),
  .index_beyond_count (index_beyond_count)
);
`default_nettype wire

/* tb/radical_inverse_sequence_tb.sv */
// self-checking testbench for the radical inverse sample point generator
`default_nettype none
module radical_inverse_sequence_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import rinv_pkg::*;

  localparam int RANDOM_POINTS = 1900;
  localparam int STALL_LIMIT   = 20000;
  localparam int HOLD_CYCLES   = 3000;

  typedef struct packed {
    logic [31:0] x;
    logic [31:0] y;
    logic        beyond;
  } point_t;

  typedef struct {
    logic [31:0] index;
    logic        known;
    point_t      pt;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic write_enable = 1'b0;
  logic [REG_BITS-1:0] reg_index = '0;
  logic [DATA_BITS-1:0] write_data = '0;
  logic sample_valid = 1'b0;
  logic sample_ready;
  logic [31:0] sample_index = '0;
  logic result_valid;
  logic result_ready = 1'b0;
  logic [31:0] x_frac, y_frac;
  logic index_beyond_count;

  // model copy of the registers
  logic        cfg_kind;
  logic [7:0]  cfg_first, cfg_second;
  logic [31:0] cfg_count;

  point_t pending_points[$];
  int mismatches = 0;
  int idle_cycles = 0;
  bit hold_request = 1'b0;

  always #1 clk = ~clk;

  radical_inverse_sequence dut (.*);

  // exact floored radical inverse of the index in the given base
  function automatic logic [31:0] reverse_digits(logic [31:0] index, logic [7:0] base);
    logic [7:0] digit_stack[32];
    logic [63:0] rest, acc, b;
    int n;
    b = (base < 2) ? 64'd2 : {56'd0, base};
    rest = {32'd0, index};
    acc = 0;
    n = 0;
    while (rest != 0) begin
      digit_stack[n] = 8'(rest % b);
      rest = rest / b;
      n++;
    end
    while (n > 0) begin
      n--;
      acc = ((({56'd0, digit_stack[n]}) << 32) + acc) / b;
    end
    return acc[31:0];
  endfunction

  function automatic point_t predict_point(logic [31:0] index);
    point_t p;
    logic [63:0] q;
    p.beyond = 1'b0;
    if (cfg_kind == KIND_HALTON) begin
      p.x = reverse_digits(index, cfg_first);
      p.y = reverse_digits(index, cfg_second);
    end else begin
      p.y = reverse_digits(index, cfg_first);
      if (index >= cfg_count) begin
        p.x = '1;
        p.beyond = 1'b1;
      end else begin
        q = ({32'd0, index} << 32) / {32'd0, cfg_count};
        p.x = q[31:0];
      end
    end
    return p;
  endfunction

  task automatic write_reg(logic [REG_BITS-1:0] idx, logic [31:0] value);
    @(posedge clk);
    write_enable <= 1'b1;
    reg_index <= idx;
    write_data <= value;
    case (idx)
      REG_KIND:   cfg_kind = value[0];
      REG_FIRST:  cfg_first = value[7:0];
      REG_SECOND: cfg_second = value[7:0];
      default:    cfg_count = value;
    endcase
    @(posedge clk);
    write_enable <= 1'b0;
  endtask

  task automatic write_setup(logic kind, logic [7:0] b1, logic [7:0] b2, logic [31:0] cnt);
    write_reg(REG_KIND, {31'd0, kind});
    write_reg(REG_FIRST, {24'd0, b1});
    write_reg(REG_SECOND, {24'd0, b2});
    write_reg(REG_COUNT, cnt);
  endtask

  // offer one index and wait for its transfer
  task automatic send_index(logic [31:0] index, point_t expected);
    @(posedge clk);
    sample_valid <= 1'b1;
    sample_index <= index;
    pending_points.push_back(expected);
    do @(posedge clk); while (!sample_ready);
    sample_valid <= 1'b0;
  endtask

  task automatic drain;
    while (pending_points.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);
  endtask

  // random index biased toward small values and toward the count, so counts are hit often
  function automatic logic [31:0] pick_index();
    case ($urandom_range(0, 3))
      0: return $urandom_range(0, 64);
      1: return $urandom_range(0, 4096);
      2: return cfg_count + $urandom_range(0, 3) - 2;
      default: return $urandom;
    endcase
  endfunction

  task automatic random_phase(int points);
    int burst;
    int sent;
    sent = 0;
    while (sent < points) begin
      burst = $urandom_range(1, 12);
      repeat (burst) begin
        logic [31:0] idx;
        idx = pick_index();
        send_index(idx, predict_point(idx));
        sent++;
      end
      if ($urandom_range(0, 2) != 0) repeat ($urandom_range(1, 30)) @(posedge clk);
    end
  endtask

  // directed stimulus, reset register values
  stim_row_t directed_rows[] = '{
    '{32'd0,          1'b1, '{32'h0000_0000, 32'h0000_0000, 1'b0}},
    '{32'd1,          1'b1, '{32'h0040_0000, 32'h8000_0000, 1'b0}},
    '{32'd512,        1'b1, '{32'h8000_0000, 32'h0040_0000, 1'b0}},
    '{32'd1023,       1'b0, '{32'h0, 32'h0, 1'b0}},
    '{32'd1024,       1'b1, '{32'hFFFF_FFFF, 32'h0020_0000, 1'b1}},
    '{32'hFFFF_FFFF,  1'b1, '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1}},
    '{32'h8000_0000,  1'b1, '{32'hFFFF_FFFF, 32'h0000_0001, 1'b1}},
    '{32'h5555_5555,  1'b0, '{32'h0, 32'h0, 1'b0}},
    '{32'hAAAA_AAAA,  1'b0, '{32'h0, 32'h0, 1'b0}}
  };

  // receiver stall pattern, with a long hold-off on request
  always @(posedge clk) begin
    if (rst) begin
      result_ready <= 1'b0;
    end else if (hold_request) begin
      result_ready <= 1'b0;
    end else begin
      result_ready <= ($urandom_range(0, 7) < 5);
    end
  end

  // result check against the oldest expectation
  always @(posedge clk) begin
    point_t want;
    if (!rst && result_valid && result_ready) begin
      if (pending_points.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result x=%h y=%h", x_frac, y_frac);
      end else begin
        want = pending_points.pop_front();
        if (want.x !== x_frac || want.y !== y_frac || want.beyond !== index_beyond_count) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch exp x=%h y=%h f=%b got x=%h y=%h f=%b",
                     want.x, want.y, want.beyond, x_frac, y_frac, index_beyond_count);
        end
      end
    end
  end

  // watchdog on cycles with no transfer
  always @(posedge clk) begin
    if ((sample_valid && sample_ready) || (result_valid && result_ready) || rst)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles > STALL_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  initial begin
    point_t exp_pt;
    cfg_kind = KIND_HAMMERSLEY;
    cfg_first = 8'd2;
    cfg_second = 8'd3;
    cfg_count = 32'd1024;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // directed table with reset values
    foreach (directed_rows[i]) begin
      exp_pt = directed_rows[i].known ? directed_rows[i].pt : predict_point(directed_rows[i].index);
      send_index(directed_rows[i].index, exp_pt);
    end
    drain();

    // extremes: halton with bases 255 and 0, hammersley with base 1 and zero count, full count
    write_setup(KIND_HALTON, 8'd255, 8'd0, 32'd0);
    foreach (directed_rows[i]) send_index(directed_rows[i].index, predict_point(directed_rows[i].index));
    drain();
    write_setup(KIND_HAMMERSLEY, 8'd1, 8'd2, 32'd0);
    send_index(32'd0, '{32'hFFFF_FFFF, 32'h0, 1'b1});
    send_index(32'd7, predict_point(32'd7));
    drain();
    write_setup(KIND_HAMMERSLEY, 8'd2, 8'd3, 32'hFFFF_FFFF);
    send_index(32'hFFFF_FFFE, predict_point(32'hFFFF_FFFE));
    send_index(32'hFFFF_FFFF, '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1});
    drain();

    // long receiver hold while items keep coming
    fork
      begin
        hold_request = 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_request = 1'b0;
      end
      begin
        repeat (6) begin
          logic [31:0] held_idx;
          held_idx = 32'($urandom_range(0, 255));
          send_index(held_idx, predict_point(held_idx));
        end
      end
    join
    drain();

    // random phases over several settings
    for (int phase = 0; phase < 8; phase++) begin
      write_setup(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)),
                  8'($urandom_range(0, 255)),
                  ($urandom_range(0, 1) != 0) ? 32'($urandom_range(1, 5000)) : 32'($urandom));
      random_phase(RANDOM_POINTS / 8);
      drain();
    end

    if (mismatches == 0 && pending_points.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end
endmodule
`default_nettype wire
